// ===== design/dted_pkg.sv =====
// Shared types, constants and calendar tables for the date text to epoch days core.
package dted_pkg;

  localparam int unsigned POS_LIMIT  = 31;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MON_W  = 5;
  localparam int unsigned DAY_W  = 6;
  localparam int unsigned DAYS_W = 23;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // a negative year is held as NEG_BASE plus its magnitude
  localparam logic [YEAR_W-1:0] NEG_BASE = 14'd10000;

  // year offset that keeps every year positive and is a multiple of 400
  localparam logic [YEAR_W-1:0] YEAR_OFS     = 14'd2000;
  localparam logic [YEAR_W-1:0] NEG_YEAR_OFS = 14'd12000;

  // floor(x / 100) == (x * RECIP_100) >> 19 for x below 43699
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SH  = 19;

  localparam logic signed [24:0] DAYS_BIAS = -25'sd1449953;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LAYOUT = 2'd1,
    ST_NUMBER = 2'd2,
    ST_DATE   = 2'd3
  } status_e;

  // one parsed date string, handed from the front to the back
  typedef struct packed {
    status_e             status;
    logic [YEAR_W-1:0]   year_acc;
    logic [MON_W-1:0]    mon;
    logic [DAY_W-1:0]    day;
  } dted_rec_t;

  // day of year, counted from March 1, at the first of month m
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [3:0] m, input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:                       r = leap ? 6'd29 : 6'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 6'd30;
      default:                    r = 6'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== design/dted_front.sv =====
// Character parser: tracks both date layouts and emits one record per string.
module dted_front #(
  parameter int unsigned PosLimit = dted_pkg::POS_LIMIT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                push_valid_o,
  output dted_pkg::dted_rec_t push_data_o,
  input  logic                push_ready_i
);
  import dted_pkg::*;

  localparam int unsigned PW = $clog2(PosLimit + 1);

  typedef struct packed {
    logic              err;
    logic [YEAR_W-1:0] acc;
  } ystep_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic ystep_t year_push(input logic [YEAR_W-1:0] acc, input logic [1:0] pos,
                                       input logic [7:0] c);
    ystep_t r;
    r.err = 1'b0;
    r.acc = acc;
    if (pos == 2'd0) begin
      if (c == CH_DASH) begin
        r.acc = NEG_BASE;
      end else if (is_digit(c)) begin
        r.acc = YEAR_W'(c[3:0]);
      end else begin
        r.err = 1'b1;
        r.acc = '0;
      end
    end else if (!is_digit(c)) begin
      r.err = 1'b1;
    end else if (acc >= NEG_BASE) begin
      r.acc = NEG_BASE + YEAR_W'((acc - NEG_BASE) * YEAR_W'(10)) + YEAR_W'(c[3:0]);
    end else begin
      r.acc = YEAR_W'(acc * YEAR_W'(10)) + YEAR_W'(c[3:0]);
    end
    return r;
  endfunction

  logic [PW-1:0]     pos_q, pos_d;
  logic [1:0]        slash_q, slash_d;
  logic [2:0]        iso_flags_q, iso_flags_d;   // dash at 4, dash at 7, number error
  logic [YEAR_W-1:0] iso_year_q, iso_year_d;
  logic [3:0]        iso_mon_q, iso_mon_d;
  logic [DAY_W-1:0]  iso_day_q, iso_day_d;
  logic [MON_W-1:0]  us_mon_q, us_mon_d;
  logic [DAY_W-1:0]  us_day_q, us_day_d;
  logic [YEAR_W-1:0] us_year_q, us_year_d;
  logic [4:0]        flen_q, flen_d;
  logic [2:0]        err_q, err_d;               // month, day, year

  logic       dig_ok;
  logic [3:0] dig;
  logic [4:0] flen_inc;
  logic [7:0] iso_mon_x;
  logic [9:0] iso_day_x;
  logic [8:0] us_mon_x;
  logic [9:0] us_day_x;
  ystep_t     iso_ys, us_ys;
  logic       accept;

  assign dig_ok    = is_digit(ch_i);
  assign dig       = ch_i[3:0];
  assign flen_inc  = (flen_q == 5'd31) ? flen_q : flen_q + 5'd1;
  assign iso_mon_x = 8'(iso_mon_q) * 8'd10 + 8'(dig);
  assign iso_day_x = 10'(iso_day_q) * 10'd10 + 10'(dig);
  assign us_mon_x  = 9'(us_mon_q) * 9'd10 + 9'(dig);
  assign us_day_x  = 10'(us_day_q) * 10'd10 + 10'(dig);
  assign iso_ys    = year_push(iso_year_q, pos_q[1:0], ch_i);
  assign us_ys     = year_push(us_year_q, flen_q[1:0], ch_i);

  always_comb begin
    iso_flags_d = iso_flags_q;
    iso_year_d  = iso_year_q;
    iso_mon_d   = iso_mon_q;
    iso_day_d   = iso_day_q;
    slash_d     = slash_q;
    us_mon_d    = us_mon_q;
    us_day_d    = us_day_q;
    us_year_d   = us_year_q;
    flen_d      = flen_q;
    err_d       = err_q;
    pos_d       = (pos_q < PW'(PosLimit)) ? pos_q + PW'(1) : pos_q;

    // fixed YYYY-MM-DD layout
    if (pos_q < PW'(4)) begin
      iso_year_d = iso_ys.acc;
      if (iso_ys.err) iso_flags_d[2] = 1'b1;
    end else if (pos_q == PW'(4) || pos_q == PW'(7)) begin
      if (ch_i == CH_DASH) begin
        if (pos_q == PW'(4)) iso_flags_d[0] = 1'b1;
        else                 iso_flags_d[1] = 1'b1;
      end
    end else if (pos_q < PW'(10)) begin
      if (!dig_ok) begin
        iso_flags_d[2] = 1'b1;
      end else if (pos_q == PW'(5)) begin
        iso_mon_d = dig;
      end else if (pos_q == PW'(6)) begin
        iso_mon_d = (iso_mon_x > 8'd15) ? 4'd15 : iso_mon_x[3:0];
      end else if (pos_q == PW'(8)) begin
        iso_day_d = DAY_W'(dig);
      end else begin
        iso_day_d = (iso_day_x > 10'd63) ? 6'd63 : iso_day_x[5:0];
      end
    end

    // M/D/YYYY layout
    if (slash_q < 2'd2 && ch_i == CH_SLASH) begin
      if (flen_q == 5'd0) begin
        if (slash_q == 2'd0) err_d[0] = 1'b1;
        else                 err_d[1] = 1'b1;
      end
      slash_d = slash_q + 2'd1;
      flen_d  = '0;
    end else if (slash_q < 2'd2) begin
      if (!dig_ok) begin
        if (slash_q == 2'd0) err_d[0] = 1'b1;
        else                 err_d[1] = 1'b1;
      end else if (slash_q == 2'd0) begin
        us_mon_d = (us_mon_x > 9'd31) ? 5'd31 : us_mon_x[4:0];
      end else begin
        us_day_d = (us_day_x > 10'd63) ? 6'd63 : us_day_x[5:0];
      end
      flen_d = flen_inc;
    end else begin
      if (flen_q < 5'd4) begin
        us_year_d = us_ys.acc;
        if (us_ys.err) err_d[2] = 1'b1;
      end
      flen_d = flen_inc;
    end
  end

  // record built from the state as it stands after this character
  always_comb begin
    if (pos_q == PW'(9) && iso_flags_d[1:0] == 2'b11) begin
      push_data_o.status   = iso_flags_d[2] ? ST_NUMBER : ST_OK;
      push_data_o.year_acc = iso_year_d;
      push_data_o.mon      = MON_W'(iso_mon_d);
      push_data_o.day      = iso_day_d;
    end else begin
      if (slash_d < 2'd2)           push_data_o.status = ST_LAYOUT;
      else if (err_d[1:0] != 2'b00) push_data_o.status = ST_NUMBER;
      else if (flen_d != 5'd4)      push_data_o.status = ST_LAYOUT;
      else if (err_d[2])            push_data_o.status = ST_NUMBER;
      else                          push_data_o.status = ST_OK;
      push_data_o.year_acc = us_year_d;
      push_data_o.mon      = us_mon_d;
      push_data_o.day      = us_day_d;
    end
  end

  // only the last character of a string needs room in the queue
  assign in_ready_o   = !last_i || push_ready_i;
  assign push_valid_o = in_valid_i && last_i;
  assign accept       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      slash_q     <= '0;
      iso_flags_q <= '0;
      iso_year_q  <= '0;
      iso_mon_q   <= '0;
      iso_day_q   <= '0;
      us_mon_q    <= '0;
      us_day_q    <= '0;
      us_year_q   <= '0;
      flen_q      <= '0;
      err_q       <= '0;
    end else if (accept && last_i) begin
      pos_q       <= '0;
      slash_q     <= '0;
      iso_flags_q <= '0;
      iso_year_q  <= '0;
      iso_mon_q   <= '0;
      iso_day_q   <= '0;
      us_mon_q    <= '0;
      us_day_q    <= '0;
      us_year_q   <= '0;
      flen_q      <= '0;
      err_q       <= '0;
    end else if (accept) begin
      pos_q       <= pos_d;
      slash_q     <= slash_d;
      iso_flags_q <= iso_flags_d;
      iso_year_q  <= iso_year_d;
      iso_mon_q   <= iso_mon_d;
      iso_day_q   <= iso_day_d;
      us_mon_q    <= us_mon_d;
      us_day_q    <= us_day_d;
      us_year_q   <= us_year_d;
      flen_q      <= flen_d;
      err_q       <= err_d;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(PosLimit))
    else $error("char position past its limit");

  a_slash_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slash_q <= 2'd2)
    else $error("slash count past two");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> pos_q == '0 && slash_q == 2'd0 && flen_q == 5'd0)
    else $error("parser not restarted after last character");

endmodule

// ===== design/dted_fifo.sv =====
// Short record queue between the parser and the day calculator.
module dted_fifo #(
  parameter int unsigned Depth = dted_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  dted_pkg::dted_rec_t push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output dted_pkg::dted_rec_t pop_data_o,
  input  logic                pop_ready_i
);
  import dted_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dted_rec_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    if (push && !pop)      count_d = count_q + CntW'(1);
    else if (pop && !push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count past depth");

endmodule

// ===== design/dted_back.sv =====
// Day calculator: four-stage pipeline from a parsed record to days and status.
module dted_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  dted_pkg::dted_rec_t           in_data_i,
  output logic                          in_ready_o,
  output logic signed [dted_pkg::DAYS_W-1:0] days_o,
  output logic [1:0]                    status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);
  import dted_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage 1: offset year, month range
  status_e           st1_q;
  logic [YEAR_W-1:0] yp1_q, yy1_q;
  logic [3:0]        mon1_q;
  logic [DAY_W-1:0]  day1_q;
  logic              mok1_q;
  logic              neg;
  logic [YEAR_W-1:0] yp1_d;

  // stage 2: divide by 100
  status_e           st2_q;
  logic [YEAR_W-1:0] yp2_q, yy2_q;
  logic [3:0]        mon2_q;
  logic [DAY_W-1:0]  day2_q;
  logic              mok2_q;
  logic [6:0]        qp2_q, qy2_q;
  logic [26:0]       prod_p, prod_y;

  // stage 3: leap year, calendar check, partial day sum
  status_e           st3_q, st3_d;
  logic [6:0]        qy3_q;
  logic [8:0]        doy3_q;
  logic [23:0]       yd3_q;
  logic [YEAR_W-1:0] rem100;
  logic              leap, cal_ok;

  // stage 4: output register
  status_e           st4_q;
  logic signed [DAYS_W-1:0] days4_q;
  logic signed [24:0]       sum4;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  assign neg   = in_data_i.year_acc >= NEG_BASE;
  assign yp1_d = neg ? NEG_YEAR_OFS - in_data_i.year_acc : YEAR_OFS + in_data_i.year_acc;

  assign prod_p = 27'(yp1_q) * 27'(RECIP_100);
  assign prod_y = 27'(yy1_q) * 27'(RECIP_100);

  assign rem100 = yp2_q - YEAR_W'(14'(qp2_q) * 14'd100);
  assign leap   = (yp2_q[1:0] == 2'b00) && ((rem100 != '0) || (qp2_q[1:0] == 2'b00));
  assign cal_ok = mok2_q && (day2_q <= month_len(mon2_q, leap));
  assign st3_d  = (st2_q == ST_OK && !cal_ok) ? ST_DATE : st2_q;

  assign sum4 = $signed({1'b0, yd3_q}) - $signed({18'b0, qy3_q})
              + $signed({20'b0, qy3_q[6:2]}) + $signed({16'b0, doy3_q}) + DAYS_BIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      st1_q  <= in_data_i.status;
      yp1_q  <= yp1_d;
      // January and February count with the previous year
      yy1_q  <= (in_data_i.mon <= MON_W'(2)) ? yp1_d - YEAR_W'(1) : yp1_d;
      mon1_q <= in_data_i.mon[3:0];
      day1_q <= in_data_i.day;
      mok1_q <= (in_data_i.mon >= MON_W'(1)) && (in_data_i.mon <= MON_W'(12))
                && (in_data_i.day != '0);
    end
    if (en2) begin
      st2_q  <= st1_q;
      yp2_q  <= yp1_q;
      yy2_q  <= yy1_q;
      mon2_q <= mon1_q;
      day2_q <= day1_q;
      mok2_q <= mok1_q;
      qp2_q  <= prod_p[RECIP_SH+6:RECIP_SH];
      qy2_q  <= prod_y[RECIP_SH+6:RECIP_SH];
    end
    if (en3) begin
      st3_q  <= st3_d;
      qy3_q  <= qy2_q;
      doy3_q <= month_base(mon2_q) + 9'(day2_q) - 9'd1;
      yd3_q  <= 24'(yy2_q) * 24'd365 + 24'(yy2_q[YEAR_W-1:2]);
    end
    if (en4) begin
      st4_q   <= st3_q;
      days4_q <= (st3_q == ST_OK) ? sum4[DAYS_W-1:0] : '0;
    end
  end

  assign out_valid_o = v4_q;
  assign status_o    = st4_q;
  assign days_o      = days4_q;

  a_days_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> days_o == '0)
    else $error("nonzero days with a failing status");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !en4 |=> v3_q && v4_q)
    else $error("stage three lost a transaction during a stall");

endmodule

// ===== design/date_text_to_epoch_days_core.sv =====
// Top level: date string characters in, days since 1970-01-01 and status out.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   ch_i, last_i
//   output   out        out_valid_o / out_ready_i days_o, status_o
//
// One character per cycle while in_ready_o is high. When a string's last character is
// taken, its record is written into the queue; it then passes into the first calculator
// stage and three more stages to the output register; results flow one per cycle while out_ready_i is high.
// Reset clears parser state, queue and stage valids at once.
// A full queue stalls only a last character; other characters keep flowing.
module date_text_to_epoch_days_core #(
  parameter int unsigned PosLimit  = dted_pkg::POS_LIMIT,
  parameter int unsigned FifoDepth = dted_pkg::FIFO_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [7:0]                         ch_i,
  input  logic                               last_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  output logic signed [dted_pkg::DAYS_W-1:0] days_o,
  output logic [1:0]                         status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);
  import dted_pkg::*;

  logic      push_valid, push_ready;
  dted_rec_t push_data;
  logic      pop_valid, pop_ready;
  dted_rec_t pop_data;

  dted_front #(
    .PosLimit(PosLimit)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  dted_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_ready_i (pop_ready)
  );

  dted_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pop_valid),
    .in_data_i  (pop_data),
    .in_ready_o (pop_ready),
    .days_o     (days_o),
    .status_o   (status_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

endmodule

// ===== tb/tb_date_text_to_epoch_days_core.sv =====
// Testbench for date_text_to_epoch_days_core: directed and random date strings against a cycle-free predictor.
module tb_date_text_to_epoch_days_core;
  import dted_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [2:0] ISO_DASH4 = 3'b001;
  localparam logic [2:0] ISO_DASH7 = 3'b010;
  localparam logic [2:0] ISO_BAD   = 3'b100;
  localparam logic [3:0] ERR_MON   = 4'b0001;
  localparam logic [3:0] ERR_DAY   = 4'b0010;
  localparam logic [3:0] ERR_YEAR  = 4'b0100;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } date_char_t;

  typedef struct packed {
    logic signed [DAYS_W-1:0] days;
    status_e                  status;
  } date_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [7:0] ch_i = '0;
  logic last_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [DAYS_W-1:0] days_o;
  logic [1:0] status_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;

  date_char_t   char_q[$];
  date_result_t due_q[$];
  logic [7:0]   text_buf[$];
  date_result_t want;
  int fails = 0;
  int cycles = 0;
  int in_wait = 0;
  int out_wait = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  // parser state of the predictor
  logic [4:0]  pos_r = '0;
  logic [1:0]  slashes_r = '0;
  logic [2:0]  iso_flags_r = '0;
  logic [13:0] iso_year_r = '0;
  logic [9:0]  iso_md_r = '0;
  logic [4:0]  us_mon_r = '0;
  logic [5:0]  us_day_r = '0;
  logic [13:0] us_year_r = '0;
  logic [4:0]  flen_r = '0;
  logic [3:0]  errs_r = '0;

  date_text_to_epoch_days_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .days_o     (days_o),
    .status_o   (status_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_num(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int clip(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  // callers flag a bad year character themselves; this only updates the accumulator
  function automatic logic [13:0] push_year_digit(input logic [13:0] acc, input int idx,
                                                  input logic [7:0] c);
    if (idx == 0) begin
      if (c == CH_DASH) return NEG_BASE;
      if (is_num(c)) return 14'(c - CH_ZERO);
      return '0;
    end
    if (!is_num(c)) return acc;
    if (acc >= NEG_BASE)
      return 14'(int'(NEG_BASE) + int'(acc - NEG_BASE) * 10 + int'(c - CH_ZERO));
    return 14'(int'(acc) * 10 + int'(c - CH_ZERO));
  endfunction

  function automatic bit year_char_ok(input int idx, input logic [7:0] c);
    return is_num(c) || (idx == 0 && c == CH_DASH);
  endfunction

  function automatic int signed_year(input logic [13:0] acc);
    return (acc >= NEG_BASE) ? -int'(acc - NEG_BASE) : int'(acc);
  endfunction

  function automatic int days_in_month(input int y, input int m);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // days from 1970-01-01, eras of 400 years counted from March 1
  function automatic int civil_day_count(input int y, input int m, input int d);
    int yy, era, yoe, mp, doy, doe;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = ((yy >= 0) ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic logic [7:0] noise_char();
    string pool = "0123456789/-";
    return pool[$urandom_range(0, 11)];
  endfunction

  task automatic clear_parse_state();
    pos_r = '0; slashes_r = '0; iso_flags_r = '0; iso_year_r = '0; iso_md_r = '0;
    us_mon_r = '0; us_day_r = '0; us_year_r = '0; flen_r = '0; errs_r = '0;
  endtask

  task automatic take_date_char(input logic [7:0] c, input logic fin);
    int p, dg, mon, day, yr, dd;
    status_e st;
    date_result_t res;
    p  = int'(pos_r);
    dg = int'(c) - int'(CH_ZERO);

    // ISO layout
    if (p < 4) begin
      if (!year_char_ok(p, c)) iso_flags_r |= ISO_BAD;
      iso_year_r = push_year_digit(iso_year_r, p, c);
    end else if (p == 4 || p == 7) begin
      if (c == CH_DASH) iso_flags_r |= (p == 4) ? ISO_DASH4 : ISO_DASH7;
    end else if (p < 10) begin
      if (!is_num(c)) begin
        iso_flags_r |= ISO_BAD;
      end else begin
        mon = int'(iso_md_r[9:6]);
        day = int'(iso_md_r[5:0]);
        case (p)
          5:       mon = dg;
          6:       mon = clip(mon * 10 + dg, 15);
          8:       day = dg;
          default: day = clip(day * 10 + dg, 63);
        endcase
        iso_md_r = {mon[3:0], day[5:0]};
      end
    end

    // slash layout
    if (slashes_r < 2 && c == CH_SLASH) begin
      if (flen_r == 0) errs_r |= (slashes_r == 0) ? ERR_MON : ERR_DAY;
      slashes_r++;
      flen_r = '0;
    end else if (slashes_r < 2) begin
      if (!is_num(c)) errs_r |= (slashes_r == 0) ? ERR_MON : ERR_DAY;
      else if (slashes_r == 0) us_mon_r = 5'(clip(int'(us_mon_r) * 10 + dg, 31));
      else us_day_r = 6'(clip(int'(us_day_r) * 10 + dg, 63));
      flen_r = 5'(clip(int'(flen_r) + 1, 31));
    end else begin
      if (flen_r < 4) begin
        if (!year_char_ok(int'(flen_r), c)) errs_r |= ERR_YEAR;
        us_year_r = push_year_digit(us_year_r, int'(flen_r), c);
      end
      flen_r = 5'(clip(int'(flen_r) + 1, 31));
    end

    if (pos_r < POS_LIMIT) pos_r++;

    if (fin) begin
      st = ST_OK;
      dd = 0;
      if (p == 9 && (iso_flags_r & (ISO_DASH4 | ISO_DASH7)) == (ISO_DASH4 | ISO_DASH7)) begin
        if (iso_flags_r & ISO_BAD) st = ST_NUMBER;
        mon = int'(iso_md_r[9:6]);
        day = int'(iso_md_r[5:0]);
        yr  = signed_year(iso_year_r);
      end else begin
        if (slashes_r < 2) st = ST_LAYOUT;
        else if (errs_r & (ERR_MON | ERR_DAY)) st = ST_NUMBER;
        else if (flen_r != 4) st = ST_LAYOUT;
        else if (errs_r & ERR_YEAR) st = ST_NUMBER;
        mon = int'(us_mon_r);
        day = int'(us_day_r);
        yr  = signed_year(us_year_r);
      end
      if (st == ST_OK) begin
        if (mon < 1 || mon > 12 || day < 1 || day > days_in_month(yr, mon)) st = ST_DATE;
        else dd = civil_day_count(yr, mon, day);
      end
      res.days   = dd[DAYS_W-1:0];
      res.status = st;
      due_q.push_back(res);
      clear_parse_state();
    end
  endtask

  task automatic add_str(input string s);
    for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
  endtask

  task automatic add_digits(input int n);
    for (int k = 0; k < n; k++) text_buf.push_back(8'(int'(CH_ZERO) + $urandom_range(0, 9)));
  endtask

  task automatic add_year();
    if ($urandom_range(0, 4) == 0) begin
      text_buf.push_back(CH_DASH);
      add_str($sformatf("%03d", $urandom_range(0, 999)));
    end else begin
      add_str($sformatf("%04d", $urandom_range(0, 9999)));
    end
  endtask

  // a month or day run: usually in range, sometimes padded, rarely huge
  task automatic add_run(input int hi);
    if ($urandom_range(0, 15) == 0) begin
      add_digits($urandom_range(3, 12));
    end else begin
      if ($urandom_range(0, 6) == 0) add_digits(0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 3)) text_buf.push_back(CH_ZERO);
      end
      add_str($sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99)
                                                             : $urandom_range(1, hi)));
    end
  endtask

  // move the text buffer into the transaction queue, last flag on its final character
  task automatic end_text();
    date_char_t item;
    if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
    foreach (text_buf[k]) begin
      item.ch  = text_buf[k];
      item.fin = (k == text_buf.size() - 1);
      char_q.push_back(item);
    end
    text_buf.delete();
  endtask

  function automatic int pick_wait(input bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 1);
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      clear_parse_state();
    end else begin
      if (in_valid_i && in_ready_o) begin
        take_date_char(ch_i, last_i);
        void'(char_q.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid_i <= 1'b0;
        end else if (char_q.size() != 0) begin
          ch_i       <= char_q[0].ch;
          last_i     <= char_q[0].fin;
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_wait = pick_wait(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_wait > 0) out_wait--;
      if (out_valid_o && out_ready_i) begin
        if (due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: days %0d status %0d", days_o, status_o);
        end else begin
          want = due_q.pop_front();
          if (days_o !== want.days || status_o !== want.status) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: days exp %0d got %0d, status exp %0d got %0d",
                       want.days, days_o, want.status, status_o);
          end
        end
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        out_wait = pick_wait(out_calm);
      end
      out_ready_i <= (out_wait == 0);
    end
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int kind, idx, rand_chars, rand_strings;
    rand_chars   = 0;
    rand_strings = 0;

    // directed strings
    add_str("1970-01-01"); end_text();
    add_str("-999-01-01"); end_text();
    add_str("9999-12-31"); end_text();
    add_str("2000-02-29"); end_text();
    add_str("1900-02-29"); end_text();
    add_str("2024-1A-01"); end_text();
    add_str("1970/01-01"); end_text();
    add_str("12/31/1969"); end_text();
    add_str("99999999999/1/2000"); end_text();
    add_str("1/2/3/45"); end_text();
    add_str("1/2"); end_text();
    add_str("//2000"); end_text();
    add_str("1/2/200"); end_text();
    add_str("1/2/20x0"); end_text();
    add_str("2/29/-004"); end_text();
    add_str("00000000000000000000000000000001/1/2000"); end_text();
    add_str("3/"); text_buf.push_back(8'hFF); text_buf.push_back(8'h80); end_text();

    // random strings: mostly well formed, some mutated, some noise
    while (rand_chars < 270 || rand_strings < 20) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        add_year();
        text_buf.push_back(CH_DASH);
        add_str($sformatf("%02d", ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99)
                                                               : $urandom_range(1, 12)));
        text_buf.push_back(CH_DASH);
        add_str($sformatf("%02d", ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99)
                                                               : $urandom_range(1, 31)));
      end else if (kind < 8) begin
        add_run(12);
        text_buf.push_back(CH_SLASH);
        add_run(31);
        text_buf.push_back(CH_SLASH);
        add_year();
      end else begin
        repeat ($urandom_range(1, 40)) begin
          if ($urandom_range(0, 1) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
          else text_buf.push_back(noise_char());
        end
      end
      if (kind < 8 && $urandom_range(0, 5) == 0) begin
        idx = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: text_buf[idx] = 8'($urandom_range(0, 255));
          1: text_buf.delete(idx);
          default: text_buf.insert(idx, noise_char());
        endcase
      end
      rand_chars += text_buf.size();
      rand_strings++;
      end_text();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/dted_pkg.sv
design/dted_front.sv
design/dted_fifo.sv
design/dted_back.sv
design/date_text_to_epoch_days_core.sv
tb/tb_date_text_to_epoch_days_core.sv
